[sv/saturation_local_max_detector_macros.svh]
// Assertion macros for the checker file of the saturation local-maximum detector.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef SATURATION_LOCAL_MAX_DETECTOR_MACROS_SVH
`define SATURATION_LOCAL_MAX_DETECTOR_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SAL_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("saturation local max detector: assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("saturation local max detector: assertion failed");

`endif

[sv/sal_pkg.sv]
// Shared constants, types and the saturation compare of the saturation local-maximum detector.
// No dependencies; every other RTL file imports this package.
package sal_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;

    // Channel and packed saturation cell widths: cell = {chroma, value}.
    localparam int CH_W   = 8;
    localparam int CELL_W = 2 * CH_W;

    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    // The input row runs past the last row while the frame is flushed.
    localparam int IN_ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int WDIM_W   = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W   = $clog2(MAX_HEIGHT + 1);

    localparam int DEFAULT_WIDTH  = (512 < MAX_WIDTH) ? 512 : MAX_WIDTH;
    localparam int DEFAULT_HEIGHT = (512 < MAX_HEIGHT) ? 512 : MAX_HEIGHT;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;

    localparam int IN_DATA_W     = 3 * CH_W;
    localparam int OUT_FIELDS_W  = ROW_W + COL_W + 1;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef logic [CELL_W-1:0]   sat_cell_t;
    typedef logic [2*CELL_W-1:0] ls_word_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Line store port control.
    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
    } ls_ctl_t;

    // True when the saturation of n is strictly below that of s, by cross-multiplying.
    function automatic logic sat_lower(sat_cell_t n, sat_cell_t s);
        logic [CH_W-1:0]   cn;
        logic [CH_W-1:0]   vn;
        logic [CH_W-1:0]   cs;
        logic [CH_W-1:0]   vs;
        logic [2*CH_W-1:0] pn;
        logic [2*CH_W-1:0] ps;
        cn = n[CELL_W-1:CH_W];
        vn = n[CH_W-1:0];
        cs = s[CELL_W-1:CH_W];
        vs = s[CH_W-1:0];
        if (vn == '0)
        begin
            vn = CH_W'(1);
        end
        if (vs == '0)
        begin
            vs = CH_W'(1);
        end
        pn = (2*CH_W)'(cn) * (2*CH_W)'(vs);
        ps = (2*CH_W)'(cs) * (2*CH_W)'(vn);
        return pn < ps;
    endfunction

endpackage

[sv/sal_line_store.sv]
// Two-row line store of the saturation local-maximum detector: one word per column.
// Depends on sal_pkg. One write and one registered read per cycle, with write-to-read forwarding.
module sal_line_store
    import sal_pkg::*;
(
    input  logic     clk,
    input  ls_ctl_t  ctl,
    input  ls_word_t wr_data,
    output ls_word_t rd_data
);

    ls_word_t mem [MAX_WIDTH];
    ls_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= wr_data;
        end
    end

    // A read of the column being written in the same cycle returns the new word.
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            if (ctl.wr_en && (ctl.wr_addr == ctl.rd_addr))
            begin
                rd_data_reg <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[ctl.rd_addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/sal_win_cell.sv]
// One cell of the 3x3 window chain: holds a saturation word and compares its incoming word.
// Depends on sal_pkg for the cell type and the saturation compare.
module sal_win_cell
    import sal_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      shift_en,
    input  sat_cell_t shift_in,
    input  sat_cell_t center,
    output sat_cell_t value,
    output logic      lower
);

    sat_cell_t value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else if (shift_en)
        begin
            value_reg <= shift_in;
        end
    end

    assign value = value_reg;
    // The word shifting in is this cell's content once the window has moved.
    assign lower = sat_lower(shift_in, center);

endmodule

[sv/saturation_local_max_detector.sv]
// A pixel's decision leaves W+1 accepted items after the pixel; inside the block an
// item is registered in stage 1, then in the output register; a stalled decision holds stage 1.
// Throughput: one item per clock while the decision stream does not stall, set by the single-port-pair
// line store and the window chain. Reset (rst_n, asynchronous, active low) clears counters, window
// and valid flags and sets width and height to 512; the line store is not cleared.
// Top level of the saturation local-maximum detector; uses sal_pkg, sal_line_store, sal_win_cell.
module saturation_local_max_detector
    import sal_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Pixel stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic                  s_tuser,   // drain
    // Decision stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // row_index [8:0], col_index [17:9], is_local_max [18]
    output logic                  m_tlast,   // frame_done
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Boundary flags of the decided pixel; neighbours beyond an edge are not compared.
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } edge_mask_t;

    function automatic sat_cell_t sat_of(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b);
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        hi = (r > g) ? r : g;
        lo = (r < g) ? r : g;
        hi = (hi > b) ? hi : b;
        lo = (lo < b) ? lo : b;
        // A black pixel keeps saturation zero as chroma 0 over value 1.
        if (hi == '0)
        begin
            return CELL_W'(1);
        end
        return {hi - lo, hi};
    endfunction

    function automatic logic [WDIM_W-1:0] clamp_w(logic [CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return WDIM_W'(1);
        end
        if (int'(v) > MAX_WIDTH)
        begin
            return WDIM_W'(MAX_WIDTH);
        end
        return WDIM_W'(v);
    endfunction

    function automatic logic [HDIM_W-1:0] clamp_h(logic [CFG_DATA_W-1:0] v);
        if (v == '0)
        begin
            return HDIM_W'(1);
        end
        if (int'(v) > MAX_HEIGHT)
        begin
            return HDIM_W'(MAX_HEIGHT);
        end
        return HDIM_W'(v);
    endfunction

    // Frame geometry.
    logic [WDIM_W-1:0]   frame_w_reg, frame_w_next;
    logic [HDIM_W-1:0]   frame_h_reg, frame_h_next;

    // Position of the next input item and of the next decision.
    logic [COL_W-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0]    out_col_reg, out_col_next;
    logic [ROW_W-1:0]    out_row_reg, out_row_next;

    // Stage 1: the item whose line store words are being read.
    logic                s1_valid_reg, s1_valid_next;
    logic                s1_emit_reg;
    sat_cell_t           s1_cell_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic                s1_done_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic [COL_W-1:0]    s1_ocol_reg;
    edge_mask_t          s1_edges_reg;

    // Output register.
    logic                m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]    m_row_reg;
    logic [COL_W-1:0]    m_col_reg;
    logic                m_max_reg;
    logic                m_last_reg;

    logic                cfg_acc;
    logic                in_acc;
    logic                flushing;
    logic                ignored;
    logic                s1_load;
    logic                s1_go;
    logic                emit;
    logic                col_last;
    logic                orow_last;
    logic                ocol_last;
    logic                done;
    sat_cell_t           in_cell;
    edge_mask_t          in_edges;

    ls_ctl_t             ls_ctl;
    ls_word_t            ls_rd_data;
    ls_word_t            ls_wr_data;

    sat_cell_t           win_value [3][3];
    sat_cell_t           win_in    [3][3];
    logic                win_lower [3][3];
    sat_cell_t           new_col   [3];
    logic                is_max;

    // ---------------------------------------------------------------------------------------
    // Handshakes. The configuration port never stalls. Stage 1 moves on when its result, if
    // any, has a free output register; a new request enters whenever stage 1 is free or moving.
    // ---------------------------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign s1_go     = s1_valid_reg && (!s1_emit_reg || !m_valid_reg || m_tready);
    assign s_tready  = !s1_valid_reg || s1_go;
    assign in_acc    = s_tvalid && s_tready;

    // Once every row has arrived, each request is a flush item whatever it carries. A drain
    // request inside the frame changes nothing.
    assign flushing = in_row_reg >= IN_ROW_W'(frame_h_reg);
    assign ignored  = s_tuser && !flushing;
    assign s1_load  = in_acc && !ignored;

    assign in_cell = flushing ? '0
                              : sat_of(s_tdata[CH_W-1:0], s_tdata[2*CH_W-1:CH_W],
                                       s_tdata[3*CH_W-1:2*CH_W]);

    // The first W+1 items of a frame only fill the window and give no decision.
    assign emit = !((in_row_reg == '0) ||
                    ((in_row_reg == IN_ROW_W'(1)) && (in_col_reg == '0)));

    assign col_last  = in_col_reg == COL_W'(frame_w_reg - 1'b1);
    assign ocol_last = out_col_reg == COL_W'(frame_w_reg - 1'b1);
    assign orow_last = out_row_reg == ROW_W'(frame_h_reg - 1'b1);
    assign done      = emit && orow_last && ocol_last;

    assign in_edges.top    = out_row_reg == '0;
    assign in_edges.bottom = orow_last;
    assign in_edges.left   = out_col_reg == '0;
    assign in_edges.right  = ocol_last;

    // ---------------------------------------------------------------------------------------
    // Position counters and geometry. All position bookkeeping happens as a request is taken,
    // so the request after the frame's last decision already starts the next frame. A
    // configuration write restarts the frame.
    // ---------------------------------------------------------------------------------------
    always_comb
    begin
        frame_w_next = frame_w_reg;
        frame_h_next = frame_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_acc)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_w_next = clamp_w(cfg_data);
                REG_FRAME_HEIGHT: frame_h_next = clamp_h(cfg_data);
            endcase
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (s1_load)
        begin
            if (done)
            begin
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else
            begin
                if (col_last)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
                if (emit)
                begin
                    if (ocol_last)
                    begin
                        out_col_next = '0;
                        out_row_next = out_row_reg + 1'b1;
                    end
                    else
                    begin
                        out_col_next = out_col_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_load)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (s1_go && s1_emit_reg)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_w_reg  <= WDIM_W'(DEFAULT_WIDTH);
            frame_h_reg  <= HDIM_W'(DEFAULT_HEIGHT);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_w_reg  <= frame_w_next;
            frame_h_reg  <= frame_h_next;
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_load)
            begin
                s1_emit_reg <= emit;
            end
            m_valid_reg  <= m_valid_next;
        end
    end

    // Stage 1 payload.
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cell_reg  <= in_cell;
            s1_col_reg   <= in_col_reg;
            s1_done_reg  <= done;
            s1_row_reg   <= out_row_reg;
            s1_ocol_reg  <= out_col_reg;
            s1_edges_reg <= in_edges;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Line store. The request's column is read as it is taken; when stage 1 moves on, the upper row
    // takes the old middle word and the middle row takes the new pixel.
    // ---------------------------------------------------------------------------------------
    assign ls_ctl.rd_en   = s1_load;
    assign ls_ctl.rd_addr = in_col_reg;
    assign ls_ctl.wr_en   = s1_go;
    assign ls_ctl.wr_addr = s1_col_reg;
    assign ls_wr_data     = {ls_rd_data[CELL_W-1:0], s1_cell_reg};

    sal_line_store u_line_store (
        .clk     (clk),
        .ctl     (ls_ctl),
        .wr_data (ls_wr_data),
        .rd_data (ls_rd_data)
    );

    // ---------------------------------------------------------------------------------------
    // Window. Each row is a chain of three cells that shifts left when stage 1 moves on; the
    // right-hand cells take the upper, middle and new words. Every cell compares the word it
    // takes against the word becoming the center, so the decision sees the shifted window.
    // ---------------------------------------------------------------------------------------
    assign new_col[0] = ls_rd_data[2*CELL_W-1:CELL_W];
    assign new_col[1] = ls_rd_data[CELL_W-1:0];
    assign new_col[2] = s1_cell_reg;

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_row
        for (genvar gj = 0; gj < 3; gj++)
        begin : g_col
            if (gj == 2)
            begin : g_feed
                assign win_in[gi][gj] = new_col[gi];
            end
            else
            begin : g_link
                assign win_in[gi][gj] = win_value[gi][gj+1];
            end

            sal_win_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (s1_go),
                .shift_in (win_in[gi][gj]),
                .center   (win_value[1][2]),
                .value    (win_value[gi][gj]),
                .lower    (win_lower[gi][gj])
            );
        end
    end

    // The center itself and neighbours beyond a frame edge always pass.
    always_comb
    begin
        is_max = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if (!((i == 0) && s1_edges_reg.top) &&
                    !((i == 2) && s1_edges_reg.bottom) &&
                    !((j == 0) && s1_edges_reg.left) &&
                    !((j == 2) && s1_edges_reg.right) &&
                    !((i == 1) && (j == 1)) &&
                    !win_lower[i][j])
                begin
                    is_max = 1'b0;
                end
            end
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (s1_go && s1_emit_reg)
        begin
            m_row_reg  <= s1_row_reg;
            m_col_reg  <= s1_ocol_reg;
            m_max_reg  <= is_max;
            m_last_reg <= s1_done_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_DATA_W'({m_max_reg, m_col_reg, m_row_reg});
    assign m_tlast  = m_last_reg;

endmodule

[sv/sal_sva.sv]
// Port-level checker of the saturation local-maximum detector and its bind to the top level.
// Depends on sal_pkg and on saturation_local_max_detector_macros.svh.
`include "saturation_local_max_detector_macros.svh"

module sal_sva
    import sal_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast,
    input logic                  cfg_valid,
    input logic                  cfg_ready
);

    // A stalled decision holds its contents.
    `SAL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // With the output register empty, the pixel side must be open.
    `SAL_ASSERT_IMPLY(a_in_ready_when_out_empty, !m_tvalid, s_tready)

    // Configuration writes are never stalled.
    `SAL_ASSERT_IMPLY(a_cfg_always_ready, cfg_valid, cfg_ready)

endmodule

bind saturation_local_max_detector sal_sva u_sal_sva (.*);

[bench/saturation_local_max_detector_test.sv]
`timescale 1ns / 100ps
// Self-checking bench for saturation_local_max_detector: raster RGB frames go in with random
// gaps, decisions come out under random stalls and each is checked against a local predictor.
// Depends on sal_pkg (ports, widths, register names) and the detector RTL only.
module saturation_local_max_detector_test
    import sal_pkg::*;
();

    // Least number of requests queued over the whole run, the directed part included.
    localparam int TOTAL_ITEMS   = 1950;
    // A taken pixel passes through stage 1 to the output register; this leaves margin.
    localparam int SETTLE_CYCLES = 8;
    // The slowest correct run (about 2000 requests, each waiting out the longest gap and the
    // longest stall) stays well below this limit.
    localparam int CYCLE_LIMIT   = 800000;

    // Kinds of picture content that a frame is filled with.
    typedef enum int
    {
        CONTENT_RANDOM,
        CONTENT_PALETTE,
        CONTENT_SPARSE
    } content_t;

    typedef struct packed
    {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            drain;
    } pixel_req_t;

    typedef struct packed
    {
        cfg_reg_t              index;
        logic [CFG_DATA_W-1:0] value;
    } reg_write_t;

    typedef struct packed
    {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             peak;
        logic             last;
    } decision_t;

    // Every input of the block has a known value from time zero on.
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Pending requests for the two input channels and the decisions still owed by the block.
    pixel_req_t pixel_requests[$];
    reg_write_t reg_writes[$];
    decision_t  expected_decisions[$];

    // Predictor state: two line stores of {chroma, value} words, the 3x3 window, frame size
    // and the raster positions of the next input and the next decision.
    logic [CELL_W-1:0] upper_line [MAX_WIDTH];
    logic [CELL_W-1:0] middle_line [MAX_WIDTH];
    logic [CELL_W-1:0] window [3][3];
    int unsigned       frame_cols;
    int unsigned       frame_rows;
    int unsigned       next_row;
    int unsigned       next_col;
    int unsigned       decision_pos;

    // Frame size as the stimulus side sees it, used to shape frames and their flush.
    int unsigned       gen_cols = DEFAULT_WIDTH;
    int unsigned       gen_rows = DEFAULT_HEIGHT;
    logic [CH_W-1:0]   palette [3][3];
    // Every pixel request queued so far, drains included.
    int                queued_items = 0;

    int                error_count = 0;
    int unsigned       cycle_count = 0;
    int                gap_left = 0;
    int                stall_left = 0;
    bit                sender_calm = 1'b0;
    bit                receiver_calm = 1'b0;

    saturation_local_max_detector uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // A size register of zero means one, anything past the maximum means the maximum.
    function automatic int unsigned clamp_dimension(logic [CFG_DATA_W-1:0] v, int unsigned limit);
        if (v == '0)
        begin
            return 1;
        end
        if (32'(v) > limit)
        begin
            return limit;
        end
        return 32'(v);
    endfunction

    // Saturation kept exactly as {max - min, max}; black is chroma 0 over value 1.
    function automatic logic [CELL_W-1:0] pixel_saturation(logic [CH_W-1:0] r,
                                                            logic [CH_W-1:0] g,
                                                            logic [CH_W-1:0] b);
        logic [CH_W-1:0] hi;
        logic [CH_W-1:0] lo;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (g < lo) lo = g;
        if (b > hi) hi = b;
        if (b < lo) lo = b;
        if (hi == '0)
        begin
            return CELL_W'(1);
        end
        return {hi - lo, hi};
    endfunction

    // Strictly lower saturation of a neighbor, decided by cross-multiplying chroma and value.
    function automatic bit less_saturated(logic [CELL_W-1:0] nb, logic [CELL_W-1:0] ctr);
        int unsigned cn;
        int unsigned vn;
        int unsigned cc;
        int unsigned vc;
        cn = 32'(nb[CELL_W-1:CH_W]);
        vn = 32'(nb[CH_W-1:0]);
        cc = 32'(ctr[CELL_W-1:CH_W]);
        vc = 32'(ctr[CH_W-1:0]);
        if (vn == 0) vn = 1;
        if (vc == 0) vc = 1;
        return cn * vc < cc * vn;
    endfunction

    function automatic void restart_frame();
        next_row = 0;
        next_col = 0;
        decision_pos = 0;
    endfunction

    function automatic void predictor_reset();
        frame_cols = DEFAULT_WIDTH;
        frame_rows = DEFAULT_HEIGHT;
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_line[i] = '0;
            middle_line[i] = '0;
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                window[i][j] = '0;
            end
        end
        restart_frame();
    endfunction

    // Any register write restarts the frame from its first pixel.
    function automatic void predictor_write(logic [CFG_IDX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] value);
        if (cfg_reg_t'(index) == REG_FRAME_WIDTH)
        begin
            frame_cols = clamp_dimension(value, MAX_WIDTH);
        end
        else
        begin
            frame_rows = clamp_dimension(value, MAX_HEIGHT);
        end
        restart_frame();
    endfunction

    // Advances the window by one accepted pixel request and queues the decision it releases.
    function automatic void predict_decision(logic [IN_DATA_W-1:0] data, logic drain);
        bit                flushing;
        logic [CELL_W-1:0] sat_word;
        logic [CELL_W-1:0] up;
        logic [CELL_W-1:0] mid;
        int unsigned       p;
        int unsigned       o;
        int unsigned       r;
        int unsigned       c;
        bit                peak;
        decision_t         d;
        flushing = next_row >= frame_rows;
        // A drain inside the frame is ignored outright.
        if (!flushing && drain)
        begin
            return;
        end
        // Once the frame is flushing, pixels and drains alike push zeros through.
        sat_word = flushing ? '0 : pixel_saturation(data[CH_W-1:0], data[2*CH_W-1:CH_W],
                                                     data[3*CH_W-1:2*CH_W]);
        up = upper_line[next_col];
        mid = middle_line[next_col];
        upper_line[next_col] = mid;
        middle_line[next_col] = sat_word;
        for (int i = 0; i < 3; i++)
        begin
            window[i][0] = window[i][1];
            window[i][1] = window[i][2];
        end
        window[0][2] = up;
        window[1][2] = mid;
        window[2][2] = sat_word;

        p = next_row * frame_cols + next_col;
        next_col++;
        if (next_col >= frame_cols)
        begin
            next_col = 0;
            next_row++;
        end
        // The window center trails the input by one row and one pixel.
        if (p < frame_cols + 1)
        begin
            return;
        end

        o = decision_pos;
        r = o / frame_cols;
        c = o % frame_cols;
        peak = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                // Skip the center and every neighbor that falls outside the frame.
                if ((i == 1 && j == 1) || (i == 0 && r == 0) || (i == 2 && r + 1 >= frame_rows)
                    || (j == 0 && c == 0) || (j == 2 && c + 1 >= frame_cols))
                begin
                    continue;
                end
                if (!less_saturated(window[i][j], window[1][1]))
                begin
                    peak = 1'b0;
                end
            end
        end
        d.row = r[ROW_W-1:0];
        d.col = c[COL_W-1:0];
        d.peak = peak;
        d.last = (o + 1 >= frame_cols * frame_rows);
        if (d.last)
        begin
            restart_frame();
        end
        else
        begin
            decision_pos = o + 1;
        end
        expected_decisions.push_back(d);
    endfunction

    // Compares one accepted decision with the oldest one still owed.
    function automatic void check_decision();
        decision_t want;
        if (expected_decisions.size() == 0)
        begin
            $display("%0t: unexpected decision, tdata %h tlast %b", $time, m_tdata, m_tlast);
            error_count++;
            return;
        end
        want = expected_decisions.pop_front();
        if (m_tdata[ROW_W-1:0] !== want.row)
        begin
            $display("%0t: row_index expected %0d, got %0d", $time, want.row,
                     m_tdata[ROW_W-1:0]);
            error_count++;
        end
        if (m_tdata[ROW_W +: COL_W] !== want.col)
        begin
            $display("%0t: col_index expected %0d, got %0d", $time, want.col,
                     m_tdata[ROW_W +: COL_W]);
            error_count++;
        end
        if (m_tdata[ROW_W + COL_W] !== want.peak)
        begin
            $display("%0t: is_local_max at (%0d,%0d) expected %b, got %b", $time, want.row,
                     want.col, want.peak, m_tdata[ROW_W + COL_W]);
            error_count++;
        end
        if (m_tlast !== want.last)
        begin
            $display("%0t: frame_done at (%0d,%0d) expected %b, got %b", $time, want.row,
                     want.col, want.last, m_tlast);
            error_count++;
        end
    endfunction

    // Idle lengths: mostly none or short ones, now and then a long one, and none while calm.
    function automatic int pick_idle(bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
        begin
            return 0;
        end
        if (roll < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic pixel_req_t make_pixel(content_t mode);
        pixel_req_t px;
        int         pick;
        int         scale;
        int         level;
        px = '0;
        case (mode)
            CONTENT_RANDOM:
            begin
                {px.red, px.green, px.blue} = 24'($urandom);
            end
            CONTENT_PALETTE:
            begin
                // Scaled copies of a few base colors share their saturation exactly, so
                // ties between neighbors come up often.
                pick = $urandom_range(0, 2);
                scale = $urandom_range(1, 16);
                px.red = CH_W'(palette[pick][0] * scale);
                px.green = CH_W'(palette[pick][1] * scale);
                px.blue = CH_W'(palette[pick][2] * scale);
            end
            default:
            begin
                // Mostly gray or black with a few colored spots, giving isolated peaks.
                if ($urandom_range(0, 6) == 0)
                begin
                    {px.red, px.green, px.blue} = 24'($urandom);
                end
                else
                begin
                    level = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 255);
                    px.red = CH_W'(level);
                    px.green = CH_W'(level);
                    px.blue = CH_W'(level);
                end
            end
        endcase
        return px;
    endfunction

    task automatic push_rgb(int r, int g, int b, bit drain);
        pixel_req_t px;
        px.red = CH_W'(r);
        px.green = CH_W'(g);
        px.blue = CH_W'(b);
        px.drain = drain;
        pixel_requests.push_back(px);
        queued_items++;
    endtask

    // Queues one frame at the current size, with stray drains inside it, then the flush of
    // one row plus one item, each flush item a drain or a pixel that gets dropped.
    // A cut frame stops after a random number of pixels and gets no flush.
    task automatic queue_frame(content_t mode, bit cut);
        int         pixels;
        pixel_req_t px;
        pixels = gen_cols * gen_rows;
        if (cut)
        begin
            pixels = $urandom_range(1, pixels);
        end
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                palette[i][j] = CH_W'($urandom_range(0, 15));
            end
        end
        for (int n = 0; n < pixels; n++)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                px = make_pixel(CONTENT_RANDOM);
                px.drain = 1'b1;
                pixel_requests.push_back(px);
                queued_items++;
            end
            pixel_requests.push_back(make_pixel(mode));
        end
        queued_items += pixels;
        if (!cut)
        begin
            for (int n = 0; n <= gen_cols; n++)
            begin
                px = make_pixel(CONTENT_RANDOM);
                px.drain = 1'($urandom_range(0, 1));
                pixel_requests.push_back(px);
            end
            queued_items += gen_cols + 1;
        end
    endtask

    // Waits until every request has gone in and every decision has come out, then lets the
    // block finish any work that yields no decision. Levels are read at the falling edge.
    task automatic wait_idle();
        while (pixel_requests.size() != 0 || s_tvalid || reg_writes.size() != 0 || cfg_valid
               || expected_decisions.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes one register while the block is idle and returns once the write is taken.
    task automatic write_reg(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
        reg_write_t req;
        wait_idle();
        req.index = index;
        req.value = value;
        reg_writes.push_back(req);
        if (index == REG_FRAME_WIDTH)
        begin
            gen_cols = clamp_dimension(value, MAX_WIDTH);
        end
        else
        begin
            gen_rows = clamp_dimension(value, MAX_HEIGHT);
        end
        while (reg_writes.size() != 0 || cfg_valid)
        begin
            @(negedge clk);
        end
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_size(int most);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
        begin
            return '0;
        end
        if (roll < 75)
        begin
            return CFG_DATA_W'($urandom_range(1, 8));
        end
        return CFG_DATA_W'($urandom_range(9, most));
    endfunction

    // Pixel request driver: a new request goes out as soon as the last one is taken and its
    // idle gap, if any, has run down.
    always @(posedge clk)
    begin
        pixel_req_t px;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                gap_left = pick_idle(sender_calm);
                // Switch now and then between gappy traffic and back-to-back bursts.
                if ($urandom_range(0, 249) == 0)
                begin
                    sender_calm = !sender_calm;
                end
            end
            if (!s_tvalid || s_tready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pixel_requests.size() != 0)
                begin
                    px = pixel_requests.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {px.blue, px.green, px.red};
                    s_tuser <= px.drain;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Register write driver, one request at a time.
    always @(posedge clk)
    begin
        reg_write_t req;
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_valid <= 1'b0;
        end
        else if (!cfg_valid && reg_writes.size() != 0)
        begin
            req = reg_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= req.index;
            cfg_data <= req.value;
        end
    end

    // Decision receiver: ready for a cycle, then possibly stalled for a while.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 299) == 0)
            begin
                receiver_calm = !receiver_calm;
            end
            stall_left = pick_idle(receiver_calm);
        end
    end

    // Monitor: all three channels are sampled at the same edge, in order, so a decision is
    // always checked after the request that caused it has been predicted.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            predictor_reset();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                predictor_write(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                predict_decision(s_tdata, s_tuser);
            end
            if (m_tvalid && m_tready)
            begin
                check_decision();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int       frames;
        int       roll;
        bit       cut;
        content_t mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Single pixel frame (both sizes written as zero): no neighbors, so it is a maximum.
        // A drain before the pixel is ignored; the flush holds a dropped pixel and a drain.
        write_reg(REG_FRAME_WIDTH, '0);
        write_reg(REG_FRAME_HEIGHT, '0);
        push_rgb(8'h12, 8'h34, 8'h56, 1'b1);
        push_rgb(0, 0, 0, 1'b0);
        push_rgb(255, 255, 255, 1'b0);
        push_rgb(0, 0, 0, 1'b1);

        // Small frame with black, white, green-dominant pixels, exact ties of one half and a
        // corner peak; a drain sits in the middle of the frame.
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(3));
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(3));
        push_rgb(0, 0, 0, 1'b0);
        push_rgb(255, 255, 255, 1'b0);
        push_rgb(128, 64, 64, 1'b0);
        push_rgb(0, 200, 0, 1'b0);
        push_rgb(10, 250, 5, 1'b0);
        push_rgb(255, 0, 0, 1'b1);
        push_rgb(100, 50, 50, 1'b0);
        push_rgb(1, 1, 2, 1'b0);
        push_rgb(2, 1, 2, 1'b0);
        push_rgb(255, 254, 0, 1'b0);
        push_rgb(0, 255, 255, 1'b0);
        push_rgb(9, 9, 9, 1'b1);
        push_rgb(0, 0, 255, 1'b0);
        push_rgb(1, 2, 3, 1'b1);

        // Widest frame as a single row, then tallest frame as a single column; both sizes
        // come from an all-ones write that saturates at the maximum.
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(1));
        queue_frame(CONTENT_SPARSE, 1'b0);
        write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(1));
        write_reg(REG_FRAME_HEIGHT, '1);
        queue_frame(CONTENT_RANDOM, 1'b0);

        // Random part: mostly small frames, one to three back to back per size setting; now
        // and then the last one is cut short and the next size write restarts the frame.
        while (queued_items < TOTAL_ITEMS)
        begin
            roll = $urandom_range(0, 2);
            if (roll != 1)
            begin
                write_reg(REG_FRAME_WIDTH, random_size(40));
            end
            if (roll != 0)
            begin
                write_reg(REG_FRAME_HEIGHT, random_size(12));
            end
            frames = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
            begin
                mode = content_t'($urandom_range(0, 2));
                cut = (f == frames - 1) && ($urandom_range(0, 9) == 0);
                queue_frame(mode, cut);
            end
        end

        wait_idle();
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
